/* rtl/csba_pkg.sv */
// ----------------------------------------------------------------------------
// csba_pkg: shared types and constants of the section allocator
// Command and status codes, field widths and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package csba_pkg;

  // Fixed field widths of the request and result
  localparam int SIZE_W     = 32;
  localparam int BASE_W     = 32;
  localparam int ADDR_OUT_W = 27;
  localparam int CFG_W      = 8;

  // Reset value of the managed section count
  localparam logic [CFG_W-1:0] SECTION_COUNT_RST = 8'd128;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_FREED     = 2'd2
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_MARK  = 5'b01000,
    S_CLEAR = 5'b10000
  } state_e;

endpackage : csba_pkg

`default_nettype wire

/* rtl/csba_step.sv */
// ----------------------------------------------------------------------------
// csba_step: shared increment and bound compare
// Produces a counter's next value and flags when that value reaches a bound.
// ----------------------------------------------------------------------------
`default_nettype none

module csba_step
  import csba_pkg::*;
#(
  parameter int W = 8
) (
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] bound_i,
  output logic      [W-1:0] inc_o,
  output logic              reach_o
);

  logic [W:0] sum;

  // Increment with carry kept for the compare
  assign sum     = {1'b0, a_i} + {{W{1'b0}}, 1'b1};
  assign inc_o   = sum[W-1:0];
  assign reach_o = (sum >= {1'b0, bound_i});

endmodule : csba_step

`default_nettype wire

/* rtl/csba_bitmap.sv */
// ----------------------------------------------------------------------------
// csba_bitmap: used/free bitmap of the sections
// One bit per section, cleared by reset, one registered read and one write a
// cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csba_bitmap
  import csba_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int IW    = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [IW-1:0] rd_idx_i,
  output logic               rd_bit_o,
  input  wire logic          wr_en_i,
  input  wire logic [IW-1:0] wr_idx_i,
  input  wire logic          wr_bit_i
);

  logic [DEPTH-1:0] used_q;
  logic             rd_bit_q;

  assign rd_bit_o = rd_bit_q;

  // Register the bit under the read index; mark or release one section a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      rd_bit_q <= 1'b0;
    end else begin
      rd_bit_q <= used_q[rd_idx_i];
      if (wr_en_i) begin
        used_q[wr_idx_i] <= wr_bit_i;
      end
    end
  end

endmodule : csba_bitmap

`default_nettype wire

/* rtl/contiguous_section_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_section_bitmap_allocator: first-fit section allocator
// Allocates and frees contiguous runs of sections over a used/free bitmap.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; busy_o then
// stays high until the request is finished, and the answer appears on
// status_o/alloc_address_o for one cycle marked by done_o, which the receiver
// cannot stall. The bitmap is walked one section per cycle, with one
// increment/compare unit for the section index and one for the run length.
// An allocation first scans from section zero until a free run of the
// needed length ends (or the whole managed count is scanned when there is
// no room), then goes back and marks the run. A free clears the sections
// of its range below the managed count. The section count register may
// only be written while busy_o is low.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_section_bitmap_allocator
  import csba_pkg::*;
#(
  parameter int MAX_SECTIONS  = 128,
  parameter int SECTION_SHIFT = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Request
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic                  cmd_i,
  input  wire logic [SIZE_W-1:0]     size_bytes_i,
  input  wire logic [BASE_W-1:0]     base_address_i,
  // Result
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [ADDR_OUT_W-1:0]      alloc_address_o,
  // Section count register
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SECTIONS + 2);
  localparam int NW    = SIZE_W + 1 - SECTION_SHIFT;
  localparam int FW    = (NW + 1 > CNT_W) ? NW + 1 : CNT_W;
  localparam int LW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  state_e               state_q, state_d;
  logic                 done_q, done_d;
  logic [CFG_W-1:0]     section_count_q;
  cmd_e                 cmd_q, cmd_d;
  logic [SIZE_W-1:0]    size_q, size_d;
  logic [BASE_W-1:0]    base_q, base_d;
  logic [CNT_W-1:0]     limit_q, limit_d;
  logic [CNT_W-1:0]     need_q, need_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     run_q, run_d;
  logic [CNT_W-1:0]     start_q, start_d;
  logic [CNT_W-1:0]     end_q, end_d;
  status_e              status_q, status_d;
  logic [ADDR_OUT_W-1:0] addr_q, addr_d;

  logic                 accept;
  logic [LW-1:0]        sc_lw, lim_lw;
  logic [FW-1:0]        sec_fw, need_fw, first_fw, end_fw, limit_fw;
  logic [63:0]          addr_wide;
  logic [CNT_W-1:0]     idx_bound, idx_inc, run_inc;
  logic                 idx_reach, run_reach;
  logic                 map_bit;
  logic                 map_we, map_wbit;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Effective section count, saturated to the bitmap depth
  assign sc_lw   = LW'(section_count_q);
  assign lim_lw  = (sc_lw > LW'(MAX_SECTIONS)) ? LW'(MAX_SECTIONS) : sc_lw;
  assign limit_d = CNT_W'(lim_lw);

  // Byte size rounded up to whole sections
  assign sec_fw   = FW'(size_q[SIZE_W-1:SECTION_SHIFT]) + FW'(|size_q[SECTION_SHIFT-1:0]);
  assign need_fw  = (sec_fw == '0) ? FW'(1) : sec_fw;
  assign first_fw = FW'(base_q[BASE_W-1:SECTION_SHIFT]);
  assign end_fw   = first_fw + sec_fw;
  assign limit_fw = FW'(limit_q);

  assign addr_wide = 64'(start_q) << SECTION_SHIFT;

  // Shared index step: bound is the managed count while scanning, the run end otherwise
  assign idx_bound = (state_q == S_SCAN) ? limit_q : end_q;

  csba_step #(.W(CNT_W)) u_idx_step (
    .a_i     (idx_q),
    .bound_i (idx_bound),
    .inc_o   (idx_inc),
    .reach_o (idx_reach)
  );

  csba_step #(.W(CNT_W)) u_run_step (
    .a_i     (run_q),
    .bound_i (need_q),
    .inc_o   (run_inc),
    .reach_o (run_reach)
  );

  // Read address is the next index, so the registered bit lines up with idx_q
  csba_bitmap #(.DEPTH(MAX_SECTIONS), .IW(IDX_W)) u_bitmap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (idx_d[IDX_W-1:0]),
    .rd_bit_o (map_bit),
    .wr_en_i  (map_we),
    .wr_idx_i (idx_q[IDX_W-1:0]),
    .wr_bit_i (map_wbit)
  );

  assign map_we   = (state_q == S_MARK) || (state_q == S_CLEAR);
  assign map_wbit = (state_q == S_MARK);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    cmd_d    = cmd_q;
    size_d   = size_q;
    base_d   = base_q;
    need_d   = need_q;
    idx_d    = idx_q;
    run_d    = run_q;
    start_d  = start_q;
    end_d    = end_q;
    status_d = status_q;
    addr_d   = addr_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_e'(cmd_i);
          size_d  = size_bytes_i;
          base_d  = base_address_i;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        need_d = (need_fw > FW'(MAX_SECTIONS + 1)) ? CNT_W'(MAX_SECTIONS + 1)
                                                   : CNT_W'(need_fw);
        idx_d  = '0;
        run_d  = '0;
        if (cmd_q == CMD_ALLOC) begin
          if (limit_q == '0) begin
            done_d   = 1'b1;
            status_d = ST_NO_ROOM;
            addr_d   = '0;
            state_d  = S_IDLE;
          end else begin
            state_d = S_SCAN;
          end
        end else begin
          idx_d = CNT_W'(first_fw);
          end_d = (end_fw > limit_fw) ? limit_q : CNT_W'(end_fw);
          if ((base_q == '0) || (first_fw >= limit_fw) || (sec_fw == '0)) begin
            done_d   = 1'b1;
            status_d = ST_FREED;
            addr_d   = '0;
            state_d  = S_IDLE;
          end else begin
            state_d = S_CLEAR;
          end
        end
      end
      S_SCAN: begin
        if (!map_bit && run_reach) begin
          // Run long enough: go back to its start and mark it
          idx_d   = (run_q == '0) ? idx_q : start_q;
          start_d = (run_q == '0) ? idx_q : start_q;
          end_d   = idx_inc;
          state_d = S_MARK;
        end else begin
          if (!map_bit) begin
            run_d = run_inc;
            if (run_q == '0) begin
              start_d = idx_q;
            end
          end else begin
            run_d = '0;
          end
          if (idx_reach) begin
            done_d   = 1'b1;
            status_d = ST_NO_ROOM;
            addr_d   = '0;
            state_d  = S_IDLE;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      S_MARK: begin
        if (idx_reach) begin
          done_d   = 1'b1;
          status_d = ST_ALLOCATED;
          addr_d   = addr_wide[ADDR_OUT_W-1:0];
          state_d  = S_IDLE;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_CLEAR: begin
        if (idx_reach) begin
          done_d   = 1'b1;
          status_d = ST_FREED;
          addr_d   = '0;
          state_d  = S_IDLE;
        end else begin
          idx_d = idx_inc;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      done_q          <= 1'b0;
      section_count_q <= SECTION_COUNT_RST;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        section_count_q <= cfg_data_i;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    size_q   <= size_d;
    base_q   <= base_d;
    need_q   <= need_d;
    idx_q    <= idx_d;
    run_q    <= run_d;
    start_q  <= start_d;
    end_q    <= end_d;
    status_q <= status_d;
    addr_q   <= addr_d;
    if (accept) begin
      limit_q <= limit_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign alloc_address_o = addr_q;

  // A result is only shown once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // A taken request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request taken but block not busy");

  // Only a successful allocation carries an address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_ALLOCATED)) |-> (alloc_address_o == '0))
    else $error("address on a result that is not an allocation");

  // Bitmap is written only while a request is in progress
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_we |-> busy_o)
    else $error("bitmap write outside a request");

endmodule : contiguous_section_bitmap_allocator

`default_nettype wire

/* tb/tb_contiguous_section_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// tb_contiguous_section_bitmap_allocator: self-checking bench of the allocator
// Sends directed and random alloc/free requests over the start/busy port.
// A local copy of the section bitmap predicts each answer. Every done_o
// strobe is compared field by field with the oldest prediction. The section
// count register is rewritten between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_contiguous_section_bitmap_allocator;
  import csba_pkg::*;

  localparam int          MAX_SECTIONS   = 128;
  localparam int          SECTION_SHIFT  = 20;
  localparam logic [63:0] SECTION_BYTES  = 64'h0010_0000;
  localparam int          PHASE_ITEMS    = 485;
  localparam int          SETTLE_CYCLES  = 300;

  typedef struct packed {
    status_e                status;
    logic [ADDR_OUT_W-1:0]  address;
  } answer_t;

  typedef struct {
    int first;
    int count;
  } region_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic                   cmd_i;
  logic [SIZE_W-1:0]      size_bytes_i;
  logic [BASE_W-1:0]      base_address_i;
  logic                   done_o;
  logic [1:0]             status_o;
  logic [ADDR_OUT_W-1:0]  alloc_address_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i;

  // Predictor state: one used bit per section and the section count
  logic [MAX_SECTIONS-1:0] section_used;
  logic [CFG_W-1:0]        section_count;

  answer_t answer_q[$];
  region_t live_regions[$];
  int      mismatch_count = 0;

  contiguous_section_bitmap_allocator #(
    .MAX_SECTIONS  (MAX_SECTIONS),
    .SECTION_SHIFT (SECTION_SHIFT)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cmd_i           (cmd_i),
    .size_bytes_i    (size_bytes_i),
    .base_address_i  (base_address_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .alloc_address_o (alloc_address_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // Free-running clock, period 8
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Whole sections covered by a byte count, rounded up
  function automatic logic [63:0] sections_spanned(input logic [31:0] bytes);
    return ({32'd0, bytes} + SECTION_BYTES - 64'd1) >> SECTION_SHIFT;
  endfunction

  // Apply one request to the local bitmap and work out its answer
  function automatic answer_t predict_request(input cmd_e cmd, input logic [31:0] size,
                                              input logic [31:0] base);
    answer_t     ans;
    int          limit;
    int          run;
    int          run_start;
    bit          found;
    logic [63:0] need;
    logic [63:0] first;
    logic [63:0] last;
    limit       = (section_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(section_count);
    ans.status  = ST_NO_ROOM;
    ans.address = '0;
    run         = 0;
    run_start   = 0;
    found       = 1'b0;
    if (cmd == CMD_ALLOC) begin
      need = sections_spanned(size);
      if (need == 64'd0) need = 64'd1;
      // First fit: lowest run of free sections long enough
      for (int i = 0; i < limit && !found; i++) begin
        if (!section_used[i]) begin
          if (run == 0) run_start = i;
          run++;
          if (64'(run) >= need) begin
            for (int j = run_start; j <= i; j++) section_used[j] = 1'b1;
            ans.status  = ST_ALLOCATED;
            ans.address = ADDR_OUT_W'(64'(run_start) << SECTION_SHIFT);
            found       = 1'b1;
          end
        end else begin
          run = 0;
        end
      end
    end else begin
      ans.status = ST_FREED;
      // Address zero is ignored; clear only sections under the limit
      if (base != '0) begin
        first = {32'd0, base} >> SECTION_SHIFT;
        last  = first + sections_spanned(size);
        if (last > 64'(limit)) last = 64'(limit);
        for (longint i = first; i < last; i++) section_used[i] = 1'b0;
      end
    end
    return ans;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    mismatch_count++;
  endtask

  // Hold start high until the block takes the request, then predict it
  task automatic send_request(input cmd_e cmd, input logic [31:0] size,
                              input logic [31:0] base, output answer_t ans);
    start_i        <= 1'b1;
    cmd_i          <= cmd;
    size_bytes_i   <= size;
    base_address_i <= base;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    ans = predict_request(cmd, size, base);
    answer_q.push_back(ans);
  endtask

  task automatic sender_pause(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop start and hold off until every predicted answer has arrived
  task automatic wait_for_answers();
    start_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the section count with the block idle
  task automatic write_section_count(input logic [CFG_W-1:0] value);
    wait_for_answers();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i   <= 1'b0;
    section_count  = value;
  endtask

  // Compare each strobed answer with the oldest prediction
  always @(posedge clk_i) begin : check_answers
    answer_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("unexpected answer status=%0d address=0x%0h",
                                  status_o, alloc_address_o));
      end else begin
        want = answer_q.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d", status_o, want.status));
        if (alloc_address_o !== want.address)
          report_mismatch($sformatf("address 0x%0h, predicted 0x%0h",
                                    alloc_address_o, want.address));
      end
    end
  end

  // Size rounding on allocation, including zero and the full field
  task automatic test_alloc_sizes();
    answer_t ans;
    send_request(CMD_ALLOC, 32'd0,        $urandom(), ans);
    send_request(CMD_ALLOC, 32'd1,        $urandom(), ans);
    send_request(CMD_ALLOC, 32'h0010_0000, $urandom(), ans);
    send_request(CMD_ALLOC, 32'h0010_0001, $urandom(), ans);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, $urandom(), ans);
  endtask

  // Address zero, zero size, ranges past the limit and never-used sections
  task automatic test_free_cases();
    answer_t ans;
    send_request(CMD_FREE,  32'hFFFF_FFFF, 32'h0000_0000, ans);
    send_request(CMD_FREE,  32'd0,         32'h0010_0000, ans);
    send_request(CMD_FREE,  32'd1,         32'h0010_0000, ans);
    send_request(CMD_ALLOC, 32'h0010_0000, 32'h0000_0000, ans);
    send_request(CMD_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, ans);
    send_request(CMD_FREE,  32'h7FFF_FFFF, 32'h0030_0000, ans);
    send_request(CMD_FREE,  32'h0020_0000, 32'h0050_0000, ans);
  endtask

  // Fill the whole map, then reopen the top section
  task automatic test_full_map();
    answer_t ans;
    send_request(CMD_FREE,  32'hFFFF_FFFF, 32'h0000_0001, ans);
    send_request(CMD_ALLOC, 32'h0800_0000, 32'hFFFF_FFFF, ans);
    send_request(CMD_ALLOC, 32'd0,         32'h0000_0000, ans);
    send_request(CMD_FREE,  32'd1,         32'h07F0_0000, ans);
    send_request(CMD_ALLOC, 32'd0,         32'h5555_5555, ans);
  endtask

  // Section count of zero, above the maximum, and one
  task automatic test_section_count();
    answer_t ans;
    write_section_count(8'd0);
    send_request(CMD_ALLOC, 32'd0,         32'd0,         ans);
    send_request(CMD_FREE,  32'hFFFF_FFFF, 32'h0000_0001, ans);
    write_section_count(8'd255);
    send_request(CMD_FREE,  32'hFFFF_FFFF, 32'h0000_0001, ans);
    send_request(CMD_ALLOC, 32'h0800_0000, 32'd0,         ans);
    write_section_count(8'd1);
    send_request(CMD_FREE,  32'hFFFF_FFFF, 32'h0000_0001, ans);
    send_request(CMD_ALLOC, 32'd0,         32'd0,         ans);
    send_request(CMD_ALLOC, 32'd0,         32'd0,         ans);
  endtask

  // Mostly alloc/free pairs over live regions, some noise and full clears
  task automatic run_random_phase(input int items, input int idle_pct,
                                  input logic [CFG_W-1:0] count);
    answer_t     ans;
    region_t     region;
    cmd_e        cmd;
    logic [31:0] size;
    logic [31:0] base;
    int          pick;
    int          k;
    logic [63:0] need;
    write_section_count(count);
    live_regions.delete();
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(99) < idle_pct) sender_pause($urandom_range(1, 40));
      if ($urandom_range(199) == 0) wait_for_answers();
      pick = $urandom_range(99);
      base = $urandom();
      if (pick < 30 && live_regions.size() != 0) begin
        // Release a region handed out earlier, with a random offset
        k      = $urandom_range(live_regions.size() - 1);
        region = live_regions[k];
        live_regions.delete(k);
        cmd  = CMD_FREE;
        base = (32'(region.first) << SECTION_SHIFT) |
               ($urandom_range(1) ? $urandom_range(32'h000F_FFFF) : 32'd0);
        size = (32'(region.count) << SECTION_SHIFT) - $urandom_range(32'h000F_FFFF);
      end else if (pick < 37) begin
        cmd = CMD_FREE;
        case ($urandom_range(3))
          0:       base = 32'd0;
          1:       base = $urandom_range(32'h07FF_FFFF);
          default: base = $urandom();
        endcase
        size = $urandom_range(1) ? $urandom() : $urandom_range(32'h0040_0000);
      end else if (pick < 39) begin
        cmd  = CMD_FREE;
        base = $urandom_range(1, 32'h000F_FFFF);
        size = 32'hFFFF_FFFF;
        live_regions.delete();
      end else begin
        cmd = CMD_ALLOC;
        k   = $urandom_range(99);
        if (k < 80)      size = $urandom_range(32'h0040_0000);
        else if (k < 95) size = $urandom_range(32'h0200_0000);
        else             size = $urandom();
      end
      send_request(cmd, size, base, ans);
      if (cmd == CMD_ALLOC && ans.status == ST_ALLOCATED) begin
        need = sections_spanned(size);
        if (need == 64'd0) need = 64'd1;
        live_regions.push_back('{int'(ans.address >> SECTION_SHIFT), int'(need)});
      end
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    cmd_i          <= CMD_ALLOC;
    size_bytes_i   <= '0;
    base_address_i <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= '0;
    section_used    = '0;
    section_count   = SECTION_COUNT_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_alloc_sizes();
    test_free_cases();
    test_full_map();
    test_section_count();

    run_random_phase(PHASE_ITEMS, 12, 8'd128);
    run_random_phase(PHASE_ITEMS, 50, 8'($urandom_range(2, 127)));
    run_random_phase(PHASE_ITEMS, 0,  8'd255);

    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && answer_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
